[rtl/slc_pkg.sv]
// ----------------------------------------------------------------------------
// slc_pkg: set-associative LRU cache model, shared definitions
// Geometry constants, configuration register codes, line word and the
// result of the per-way compare unit.
// ----------------------------------------------------------------------------
package slc_pkg;

  localparam int ADDR_W       = 64;
  localparam int MAX_SET_BITS = 6;
  localparam int MAX_WAYS     = 8;
  localparam int WAY_W        = $clog2(MAX_WAYS);
  localparam int WCNT_W       = $clog2(MAX_WAYS + 1);
  localparam int ROWS         = 1 << MAX_SET_BITS;
  localparam int LINE_IDX_W   = MAX_SET_BITS + WAY_W;
  localparam int LINES        = 1 << LINE_IDX_W;
  localparam int CNT_W        = 32;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int CFG_SB_W   = 3;
  localparam int CFG_WAYS_W = 4;
  localparam int CFG_OB_W   = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET   = 2'd2;

  localparam logic [1:0] ACT_MODIFY = 2'd2;
  localparam logic [1:0] ACT_NONE   = 2'd3;

  typedef enum logic [1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_t;

  typedef struct packed {
    logic [ADDR_W-1:0] tag;
    logic [CNT_W-1:0]  stamp;
  } line_t;

  typedef struct packed {
    logic             hit;
    logic             older;
    logic [CNT_W-1:0] age;
  } way_res_t;

endpackage

[rtl/slc_way_unit.sv]
// ----------------------------------------------------------------------------
// slc_way_unit: per-way compare unit
// Checks one stored line against the block address and measures its age
// against the oldest line seen so far in the set.
// ----------------------------------------------------------------------------
module slc_way_unit import slc_pkg::*; (
  input  logic [ADDR_W-1:0] block,
  input  logic [CNT_W-1:0]  stamp,
  input  line_t             line,
  input  logic              line_vld,
  input  logic [CNT_W-1:0]  best_age,
  output way_res_t          res
);

  logic [CNT_W-1:0] age;

  // age is modulo 2^32, exact while all lines were used recently enough
  assign age       = stamp - line.stamp;
  assign res.hit   = line_vld && (line.tag == block);
  assign res.age   = age;
  assign res.older = age > best_age;

endmodule

[rtl/set_assoc_lru_cache_sim.sv]
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim: set-associative cache model with LRU replacement
// Counts hits, misses and evictions for a stream of load/store/modify items.
// ----------------------------------------------------------------------------
// Input channel: in_tdata carries the byte address, in_tuser the action
// (load, store, modify; code 3 is taken and dropped). Output channel: one
// item per access, out_tuser the outcome, out_tlast set on the final item of
// an input item, out_tdata the running hit, miss and eviction counts.
// The cfg port writes set bits, ways and offset bits. The user must write them
// only while the block is idle; the block itself does not enforce this.
// Each access scans the ways of its set one per cycle through a single
// compare unit fed by the line memory: a set-up state, the scan (cut short on
// an early hit) and a write state; a modify goes through these steps twice.
// The result lands in the output register at the end of the write cycle.
// The block is ready only between items. If the receiver stalls, the block
// still takes the next item and holds in its write cycle until the output
// register frees up.
// Reset clears the counters, the use clock and one valid flag per set at
// once, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_sim import slc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [ADDR_W-1:0]     in_tdata,   // [63:0] address
  input  logic [1:0]            in_tuser,   // [1:0] action
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [3*CNT_W-1:0]    out_tdata,  // [31:0] hit_total, [63:32] miss_total,
                                            // [95:64] eviction_total
  output logic [1:0]            out_tuser,  // [1:0] outcome
  output logic                  out_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SETUP,
    S_SCAN,
    S_WRITE
  } state_t;

  state_t                  state_r;
  logic [CFG_SB_W-1:0]     sbits_r;
  logic [CFG_WAYS_W-1:0]   ways_r;
  logic [CFG_OB_W-1:0]     obits_r;
  logic [ADDR_W-1:0]       addr_r;
  logic                    modify_r;
  logic                    second_r;
  logic [ADDR_W-1:0]       block_r;
  logic [MAX_SET_BITS-1:0] set_r;
  logic [WCNT_W-1:0]       rd_way_r;
  logic                    cmp_vld_r;
  logic [WAY_W-1:0]        cmp_way_r;
  logic [CNT_W-1:0]        best_age_r;
  logic [WAY_W-1:0]        best_way_r;
  logic [WAY_W-1:0]        way_sel_r;
  outcome_t                outcome_r;
  logic [CNT_W-1:0]        use_clock_r;
  logic [CNT_W-1:0]        hit_cnt_r;
  logic [CNT_W-1:0]        miss_cnt_r;
  logic [CNT_W-1:0]        evict_cnt_r;
  logic                    out_tvalid_r;
  outcome_t                out_tuser_r;
  logic                    out_tlast_r;

  // memories and set flags
  line_t                   line_mem [LINES];
  logic [MAX_WAYS-1:0]     mask_mem [ROWS];
  logic [ROWS-1:0]         row_vld_r;
  line_t                   line_q_r;
  logic [MAX_WAYS-1:0]     mask_q_r;
  logic                    row_q_r;

  logic [CFG_SB_W-1:0]     sbits_eff;
  logic [WCNT_W-1:0]       ways_eff;
  logic [ADDR_W-1:0]       shifted;
  logic [ADDR_W-1:0]       block_nxt;
  logic [MAX_SET_BITS-1:0] set_nxt;
  logic [MAX_WAYS-1:0]     mask_eff;
  logic                    issue;
  logic                    scan_end;
  logic                    take;
  logic                    empty_found;
  logic [WAY_W-1:0]        empty_way;
  logic                    out_free;
  logic                    line_we;
  logic                    last_nxt;
  way_res_t                wres;

  assign sbits_eff = (sbits_r > CFG_SB_W'(MAX_SET_BITS)) ? CFG_SB_W'(MAX_SET_BITS) : sbits_r;

  always_comb begin
    if (ways_r == '0) begin
      ways_eff = WCNT_W'(1);
    end else if (ways_r > WCNT_W'(MAX_WAYS)) begin
      ways_eff = WCNT_W'(MAX_WAYS);
    end else begin
      ways_eff = ways_r;
    end
  end

  assign shifted = addr_r >> obits_r;

  always_comb begin
    if ({1'b0, obits_r} >= (CFG_OB_W + 1)'(ADDR_W)) begin
      block_nxt = '0;
      set_nxt   = '0;
    end else begin
      block_nxt = addr_r & ({ADDR_W{1'b1}} << obits_r);
      set_nxt   = shifted[MAX_SET_BITS-1:0] & ~({MAX_SET_BITS{1'b1}} << sbits_eff);
    end
  end

  // a set never filled reads as all ways empty
  assign mask_eff = row_q_r ? mask_q_r : '0;

  always_comb begin
    empty_found = 1'b0;
    empty_way   = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if ((WCNT_W'(w) < ways_eff) && !mask_eff[w]) begin
        empty_found = 1'b1;
        empty_way   = WAY_W'(w);
      end
    end
  end

  slc_way_unit u_way (
    .block    (block_r),
    .stamp    (use_clock_r),
    .line     (line_q_r),
    .line_vld (mask_eff[cmp_way_r]),
    .best_age (best_age_r),
    .res      (wres)
  );

  assign issue    = (state_r == S_SCAN) && (rd_way_r < ways_eff);
  assign scan_end = ({1'b0, cmp_way_r} == (ways_eff - WCNT_W'(1)));
  assign take     = (cmp_way_r == '0) || wres.older;
  assign out_free = !out_tvalid_r || out_tready;
  assign line_we  = (state_r == S_WRITE) && out_free;
  assign last_nxt = !(modify_r && !second_r);

  // line memory: one read port for the scan, one write port
  always_ff @(posedge clk) begin
    if (issue) begin
      line_q_r <= line_mem[{set_r, rd_way_r[WAY_W-1:0]}];
    end
    if (line_we) begin
      line_mem[{set_r, way_sel_r}] <= '{tag: block_r, stamp: use_clock_r};
    end
  end

  // per-set valid masks
  always_ff @(posedge clk) begin
    mask_q_r <= mask_mem[set_r];
    if (line_we && (outcome_r == OUT_FILL)) begin
      mask_mem[set_r] <= mask_eff | (MAX_WAYS'(1) << way_sel_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      row_q_r   <= 1'b0;
    end else begin
      row_q_r <= row_vld_r[set_r];
      if (line_we && (outcome_r == OUT_FILL)) begin
        row_vld_r[set_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      sbits_r      <= '0;
      ways_r       <= CFG_WAYS_W'(1);
      obits_r      <= '0;
      modify_r     <= 1'b0;
      second_r     <= 1'b0;
      rd_way_r     <= '0;
      cmp_vld_r    <= 1'b0;
      use_clock_r  <= '0;
      hit_cnt_r    <= '0;
      miss_cnt_r   <= '0;
      evict_cnt_r  <= '0;
      out_tvalid_r <= 1'b0;
      out_tlast_r  <= 1'b0;
      out_tuser_r  <= OUT_HIT;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_SET_BITS: sbits_r <= cfg_wdata[CFG_SB_W-1:0];
          CFG_WAYS:     ways_r  <= cfg_wdata[CFG_WAYS_W-1:0];
          CFG_OFFSET:   obits_r <= cfg_wdata[CFG_OB_W-1:0];
          default: ;
        endcase
      end

      if (line_we) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            addr_r   <= in_tdata;
            modify_r <= (in_tuser == ACT_MODIFY);
            second_r <= 1'b0;
            if (in_tuser != ACT_NONE) begin
              state_r <= S_SETUP;
            end
          end
        end
        S_SETUP: begin
          block_r   <= block_nxt;
          set_r     <= set_nxt;
          rd_way_r  <= '0;
          cmp_vld_r <= 1'b0;
          state_r   <= S_SCAN;
        end
        S_SCAN: begin
          if (issue) begin
            rd_way_r <= rd_way_r + WCNT_W'(1);
          end
          cmp_vld_r <= issue;
          cmp_way_r <= rd_way_r[WAY_W-1:0];
          if (cmp_vld_r) begin
            if (wres.hit) begin
              way_sel_r <= cmp_way_r;
              outcome_r <= OUT_HIT;
              state_r   <= S_WRITE;
            end else begin
              if (take) begin
                best_age_r <= wres.age;
                best_way_r <= cmp_way_r;
              end
              if (scan_end) begin
                state_r <= S_WRITE;
                if (empty_found) begin
                  outcome_r <= OUT_FILL;
                  way_sel_r <= empty_way;
                end else begin
                  outcome_r <= OUT_EVICT;
                  way_sel_r <= take ? cmp_way_r : best_way_r;
                end
              end
            end
          end
        end
        S_WRITE: begin
          if (out_free) begin
            use_clock_r  <= use_clock_r + CNT_W'(1);
            if (outcome_r == OUT_HIT) begin
              hit_cnt_r <= hit_cnt_r + CNT_W'(1);
            end else begin
              miss_cnt_r <= miss_cnt_r + CNT_W'(1);
            end
            if (outcome_r == OUT_EVICT) begin
              evict_cnt_r <= evict_cnt_r + CNT_W'(1);
            end
            out_tuser_r  <= outcome_r;
            out_tlast_r  <= last_nxt;
            if (!last_nxt) begin
              second_r <= 1'b1;
              state_r  <= S_SETUP;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  // counters only move when the output register is free, so they can drive it
  assign out_tdata  = {evict_cnt_r, miss_cnt_r, hit_cnt_r};
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for set_assoc_lru_cache_sim
// Drives load/store/modify items through the input stream and checks every
// output item against a scoreboard that holds its own LRU cache copy and
// the hit/miss/eviction counters. Sweeps set bits, ways and offset bits
// across several settings with random input gaps and output backpressure.
// ----------------------------------------------------------------------------
module tb import slc_pkg::*; ();

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_STORE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam int ITEMS_PER_PHASE = 192;
  localparam int N_PHASES        = 8;
  localparam int DRAIN_CYCLES    = 40;
  localparam int HOLD_AT_RESULT  = 400;
  localparam int HOLD_CYCLES     = 400;
  localparam longint CYCLE_LIMIT = 1000000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [ADDR_W-1:0]     in_tdata;   // [63:0] address
  logic [1:0]            in_tuser;   // [1:0] action
  logic                  out_tvalid;
  logic                  out_tready;
  logic [3*CNT_W-1:0]    out_tdata;  // [31:0] hits, [63:32] misses, [95:64] evictions
  logic [1:0]            out_tuser;  // [1:0] outcome
  logic                  out_tlast;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  set_assoc_lru_cache_sim u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  typedef struct {
    outcome_t         outcome;
    logic             last;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] misses;
    logic [CNT_W-1:0] evicts;
  } cache_result_t;

  class lru_scoreboard;
    logic              line_ok[LINES];
    logic [ADDR_W-1:0] tag_mem[LINES];
    logic [CNT_W-1:0]  stamp_mem[LINES];
    logic [CNT_W-1:0]  use_clock, hits, misses, evicts;
    int unsigned       set_bits_r, ways_r, offset_r;
    cache_result_t     expected_q[$];
    int                errors;
    int                checked;

    function new();
      foreach (line_ok[i]) line_ok[i] = 1'b0;
      use_clock  = '0;
      hits       = '0;
      misses     = '0;
      evicts     = '0;
      set_bits_r = 0;
      ways_r     = 1;
      offset_r   = 0;
      errors     = 0;
      checked    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_SET_BITS: set_bits_r = val & 6'h07;
        CFG_WAYS:     ways_r     = val & 6'h0F;
        CFG_OFFSET:   offset_r   = val & 6'h3F;
        default: ;
      endcase
    endfunction

    function int unsigned eff_set_bits();
      return (set_bits_r > MAX_SET_BITS) ? MAX_SET_BITS : set_bits_r;
    endfunction

    function int unsigned eff_ways();
      if (ways_r == 0) return 1;
      return (ways_r > MAX_WAYS) ? MAX_WAYS : ways_r;
    endfunction

    function outcome_t lookup(logic [ADDR_W-1:0] addr);
      int unsigned      sbits, nways, row, base, w, victim;
      int               empty;
      logic [ADDR_W-1:0] blk;
      logic [CNT_W-1:0]  stamp, age, best;
      sbits  = eff_set_bits();
      nways  = eff_ways();
      stamp  = use_clock;
      use_clock = use_clock + 1;
      empty  = -1;
      victim = 0;
      best   = '0;
      if (offset_r >= ADDR_W) begin
        blk = '0;
        row = 0;
      end else begin
        blk = addr & ~((64'd1 << offset_r) - 64'd1);
        row = int'((addr >> offset_r) & ((64'd1 << sbits) - 64'd1));
      end
      base = row * MAX_WAYS;
      for (w = 0; w < nways; w++) begin
        if (line_ok[base+w] && tag_mem[base+w] == blk) begin
          stamp_mem[base+w] = stamp;
          hits = hits + 1;
          return OUT_HIT;
        end
      end
      for (w = 0; w < nways; w++) begin
        if (!line_ok[base+w]) begin
          empty = w;
          break;
        end
      end
      misses = misses + 1;
      if (empty >= 0) begin
        line_ok[base+empty]   = 1'b1;
        tag_mem[base+empty]   = blk;
        stamp_mem[base+empty] = stamp;
        return OUT_FILL;
      end
      // oldest way wins, lowest index on a tie
      for (w = 0; w < nways; w++) begin
        age = stamp - stamp_mem[base+w];
        if (w == 0 || age > best) begin
          best   = age;
          victim = w;
        end
      end
      tag_mem[base+victim]   = blk;
      stamp_mem[base+victim] = stamp;
      evicts = evicts + 1;
      return OUT_EVICT;
    endfunction

    function void push_result(outcome_t o, logic last);
      cache_result_t r;
      r.outcome = o;
      r.last    = last;
      r.hits    = hits;
      r.misses  = misses;
      r.evicts  = evicts;
      expected_q.push_back(r);
    endfunction

    function void note_item(logic [1:0] act, logic [ADDR_W-1:0] addr);
      outcome_t o;
      if (act == ACT_NONE) return;
      if (act == ACT_MODIFY) begin
        o = lookup(addr);
        push_result(o, 1'b0);
      end
      o = lookup(addr);
      push_result(o, 1'b1);
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 200) $display("ERROR result %0d: %s", checked, msg);
    endfunction

    function void cmp_field(string name, logic [CNT_W-1:0] got, logic [CNT_W-1:0] want);
      if (got !== want) report($sformatf("%s got %0d, want %0d", name, got, want));
    endfunction

    function void check_result(logic [1:0] o, logic last, logic [CNT_W-1:0] h,
                               logic [CNT_W-1:0] m, logic [CNT_W-1:0] e);
      cache_result_t want;
      checked++;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected item, outcome %0d", o));
        return;
      end
      want = expected_q.pop_front();
      cmp_field("outcome", 32'(o), 32'(want.outcome));
      cmp_field("last", 32'(last), 32'(want.last));
      cmp_field("hit_total", h, want.hits);
      cmp_field("miss_total", m, want.misses);
      cmp_field("eviction_total", e, want.evicts);
    endfunction
  endclass

  lru_scoreboard sb;
  bit     no_idle;
  int     result_count;
  longint cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      result_count++;
      sb.check_result(out_tuser, out_tlast, out_tdata[31:0], out_tdata[63:32],
                      out_tdata[95:64]);
    end
  end

  // receiver: random stalls, plus one long hold-off so the block backs up
  initial begin
    int stall;
    int r;
    bit held;
    stall = 0;
    held  = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && result_count >= HOLD_AT_RESULT) begin
        held  = 1'b1;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else if (no_idle) begin
        out_tready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_tready <= 1'b1;
        end else begin
          out_tready <= 1'b0;
          stall = (r < 95) ? $urandom_range(0, 2) : $urandom_range(7, 39);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_item(input logic [1:0] act, input logic [ADDR_W-1:0] addr,
                           input int gap);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= addr;
    do @(posedge clk); while (!in_tready);
    sb.note_item(act, addr);
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  // drop valid, wait for every expected item, then let an ignored item finish
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int ph_sb[N_PHASES] = '{3, 6, 47, 0, 2, 5, 1, 4};
    int ph_ways[N_PHASES] = '{4, 8, 63, 0, 2, 8, 3, 9};
    int ph_ob[N_PHASES] = '{4, 6, 2, 0, 63, 32, 1, 12};
    logic [ADDR_W-1:0] pool[$];
    logic [ADDR_W-1:0] addr, omask, tagr;
    logic [1:0] act;
    int unsigned sbits, nw, nrows, ob, rowsel;
    int p, k, npool, sent, r;

    sb           = new();
    result_count = 0;
    cycles       = 0;
    no_idle      = 1'b0;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = ACT_LOAD;
    cfg_we       = 1'b0;
    cfg_addr     = CFG_SET_BITS;
    cfg_wdata    = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset geometry is one set, one way, byte blocks
    send_item(ACT_LOAD,   64'h0, 0);
    send_item(ACT_STORE,  64'h0, 0);
    send_item(ACT_MODIFY, 64'h0, 2);
    send_item(ACT_LOAD,   64'hFFFF_FFFF_FFFF_FFFF, 0);
    send_item(ACT_MODIFY, 64'h0000_0000_0000_0001, 0);
    send_item(ACT_NONE,   64'h0000_0000_0000_0001, 0);
    send_item(ACT_LOAD,   64'h0000_0000_0000_0001, 1);
    send_item(ACT_NONE,   64'hFFFF_FFFF_FFFF_FFFF, 0);
    send_item(ACT_LOAD,   64'h8000_0000_0000_0000, 0);
    send_item(ACT_STORE,  64'h5555_5555_5555_5555, 0);
    send_item(ACT_STORE,  64'hAAAA_AAAA_AAAA_AAAA, 0);
    send_item(ACT_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    send_item(ACT_STORE,  64'hFFFF_FFFF_FFFF_FFFF, 0);
    send_item(ACT_MODIFY, 64'h5555_5555_5555_5555, 0);

    for (p = 0; p < N_PHASES; p++) begin
      settle();
      write_reg(CFG_SET_BITS, CFG_DATA_W'(ph_sb[p]));
      write_reg(CFG_WAYS, CFG_DATA_W'(ph_ways[p]));
      write_reg(CFG_OFFSET, CFG_DATA_W'(ph_ob[p]));
      if (p == 3) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
      no_idle = (p == 1);

      sbits = sb.eff_set_bits();
      nw    = sb.eff_ways();
      nrows = 1 << sbits;
      ob    = sb.offset_r;
      omask = (64'd1 << ob) - 64'd1;

      // two sets at most, often more blocks per set than ways to force LRU evictions
      pool.delete();
      npool = $urandom_range(1, 3 * nw + 2);
      for (k = 0; k < npool; k++) begin
        tagr   = {$urandom, $urandom};
        rowsel = $urandom_range(0, (nrows > 1) ? 1 : 0);
        pool.push_back((tagr << (ob + sbits)) | (64'(rowsel) << ob));
      end

      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        r = $urandom_range(0, 99);
        if (r < 3)       act = ACT_NONE;
        else if (r < 40) act = ACT_LOAD;
        else if (r < 70) act = ACT_STORE;
        else             act = ACT_MODIFY;
        if ($urandom_range(0, 99) < 15)
          addr = {$urandom, $urandom};
        else
          addr = pool[$urandom_range(0, pool.size() - 1)] | ({$urandom, $urandom} & omask);
        send_item(act, addr, pick_gap());
        if (act != ACT_NONE) sent++;
      end
    end

    settle();
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
